### sv/crch_pkg.sv
// ----------------------------------------------------------------------------
// crch_pkg
// Shared types, mode codes and helpers for the CRC / hash engine.
// ----------------------------------------------------------------------------
`default_nettype none

package crch_pkg;

  localparam int unsigned IndexBitsDefault = 32;
  localparam int unsigned CfgAddrW = 3;

  // configuration register indexes
  localparam logic [CfgAddrW-1:0] REG_MODE   = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_WIDTH  = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_POLY   = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_SHR    = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_REFL   = 3'd4;
  localparam logic [CfgAddrW-1:0] REG_INIT   = 3'd5;
  localparam logic [CfgAddrW-1:0] REG_FXOR   = 3'd6;

  // algorithm codes
  localparam logic [5:0] MODE_CRC_RIGHT = 6'd0;
  localparam logic [5:0] MODE_CRC_LEFT  = 6'd1;
  localparam logic [5:0] MODE_CRC_APPND = 6'd2;
  localparam logic [5:0] MODE_ROT_ADD   = 6'd3;
  localparam logic [5:0] MODE_INET      = 6'd4;
  localparam logic [5:0] MODE_XOR       = 6'd5;
  localparam logic [5:0] MODE_ADD       = 6'd6;
  localparam logic [5:0] MODE_CRC_KEEP  = 6'd7;
  localparam logic [5:0] MODE_CRC_HIGH  = 6'd8;
  localparam logic [5:0] MODE_SHL_XOR   = 6'd9;
  localparam logic [5:0] MODE_SHL_ADD   = 6'd10;
  localparam logic [5:0] MODE_DJB2      = 6'd15;
  localparam logic [5:0] MODE_MUL_ADD   = 6'd16;
  localparam logic [5:0] MODE_MUL_XOR   = 6'd17;
  localparam logic [5:0] MODE_FNV1A     = 6'd18;
  localparam logic [5:0] MODE_SDBM      = 6'd19;
  localparam logic [5:0] MODE_POS_MUL   = 6'd20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_TBL,
    ST_MUL,
    ST_UPD,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic tbl_init;
    logic tbl_step;
    logic mul_start;
    logic mul_pass2;
    logic mul_step;
    logic update;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic tbl_mode;
    logic mul_mode;
    logic pos_mode;
    logic last;
    logic tbl_done;
    logic mul_done;
    logic out_busy;
  } sts_t;

  function automatic logic is_tbl(input logic [5:0] md);
    case (md) inside
      MODE_CRC_RIGHT, MODE_CRC_LEFT, MODE_CRC_APPND, MODE_CRC_KEEP, MODE_CRC_HIGH:
        return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic is_mul(input logic [5:0] md);
    case (md) inside
      MODE_MUL_ADD, MODE_MUL_XOR, MODE_FNV1A, MODE_POS_MUL: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic is_supported(input logic [5:0] md);
    return (md <= MODE_SHL_ADD) || ((md >= MODE_DJB2) && (md <= MODE_POS_MUL));
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) r[k] = v[7-k];
    return r;
  endfunction

  function automatic logic [63:0] rev64(input logic [63:0] v);
    logic [63:0] r;
    for (int k = 0; k < 64; k++) r[k] = v[63-k];
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/crch_ctrl.sv
// ----------------------------------------------------------------------------
// crch_ctrl
// Sequencer: walks one item through table, multiply, update and emit steps.
// ----------------------------------------------------------------------------
`default_nettype none

module crch_ctrl
  import crch_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   pass2_q, pass2_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass2_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pass2_q <= pass2_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    pass2_d    = pass2_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        pass2_d = 1'b0;
        if (sts_i.tbl_mode) begin
          cmd_o.tbl_init = 1'b1;
          state_d        = ST_TBL;
        end else if (sts_i.mul_mode) begin
          cmd_o.mul_start = 1'b1;
          state_d         = ST_MUL;
        end else begin
          state_d = ST_UPD;
        end
      end
      ST_TBL: begin
        cmd_o.tbl_step = 1'b1;
        if (sts_i.tbl_done) state_d = ST_UPD;
      end
      ST_MUL: begin
        cmd_o.mul_step  = 1'b1;
        cmd_o.mul_pass2 = pass2_q;
        if (sts_i.mul_done) begin
          // position weighting needs a second product; operands reload in the datapath
          if (sts_i.pos_mode && !pass2_q) begin
            pass2_d = 1'b1;
          end else begin
            state_d = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = sts_i.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> !sts_i.out_busy) else $error("emit into a full output register");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.tbl_step && cmd_o.mul_step)) else $error("table and multiply overlap");
  a_busy_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> !in_ready_o) else $error("accepted item while busy");

endmodule

`default_nettype wire

### sv/crch_dp.sv
// ----------------------------------------------------------------------------
// crch_dp
// Datapath: config registers, running state, table bit engine, 32x32 multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module crch_dp
  import crch_pkg::*;
#(
  parameter int unsigned INDEX_BITS = IndexBitsDefault
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_valid_i,
  input  wire  [CfgAddrW-1:0] cfg_addr_i,
  input  wire  [63:0]         cfg_data_i,
  input  wire  [7:0]          in_byte_i,
  input  wire                 in_first_i,
  input  wire                 in_last_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic [63:0]         out_value_o,
  output logic                out_error_o
);

  logic [5:0]  mode_q;
  logic [6:0]  width_q;
  logic [63:0] poly_q, init_q, fxor_q;
  logic        shr_q, refl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_CRC_RIGHT;
      width_q <= 7'd32;
      poly_q  <= 64'h0000_0000_EDB8_8320;
      shr_q   <= 1'b1;
      refl_q  <= 1'b0;
      init_q  <= 64'h0000_0000_FFFF_FFFF;
      fxor_q  <= 64'h0000_0000_FFFF_FFFF;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        REG_MODE:  mode_q  <= cfg_data_i[5:0];
        REG_WIDTH: width_q <= cfg_data_i[6:0];
        REG_POLY:  poly_q  <= cfg_data_i;
        REG_SHR:   shr_q   <= cfg_data_i[0];
        REG_REFL:  refl_q  <= cfg_data_i[0];
        REG_INIT:  init_q  <= cfg_data_i;
        REG_FXOR:  fxor_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective width and mask
  logic [6:0]  w;
  logic [63:0] m;
  always_comb begin
    w = (width_q < 7'd8) ? 7'd8 : ((width_q > 7'd64) ? 7'd64 : width_q);
    m = (w == 7'd64) ? '1 : ((64'd1 << w) - 64'd1);
  end

  logic [63:0]           run_q, c_q, r_q, ma_q, mb_q, acc_q;
  logic [INDEX_BITS-1:0] bidx_q, cidx_q;
  logic [7:0]            b_q, held_q;
  logic                  last_q;
  logic [2:0]            tcnt_q;
  logic [1:0]            mstep_q;

  logic [INDEX_BITS-1:0] idx_base;
  logic [63:0]           run_base;
  assign idx_base = in_first_i ? '0 : bidx_q;
  assign run_base = in_first_i ? (init_q & m) : run_q;

  // table index and seed
  logic [63:0] ti, seed, rstep, te;
  logic [7:0]  tin;
  logic        hit;
  always_comb begin
    unique case (mode_q)
      MODE_CRC_LEFT:  ti = {56'd0, b_q} ^ (c_q >> (w - 7'd8));
      MODE_CRC_APPND: ti = c_q >> (w - 7'd8);
      default:        ti = {56'd0, b_q} ^ c_q;
    endcase
    tin   = refl_q ? rev8(ti[7:0]) : ti[7:0];
    seed  = shr_q ? {56'd0, tin} : ({56'd0, tin} << (w - 7'd8));
    hit   = shr_q ? (r_q[0] & m[0]) : ((r_q & m) >> (w - 7'd1)) != 64'd0;
    rstep = shr_q ? ((r_q & m) >> 1) : ((r_q & m) << 1);
    if (hit) rstep = rstep ^ poly_q;
    te = (refl_q ? (rev64(r_q) >> (7'd64 - w)) : r_q) & m;
  end

  // shared 32x32 multiplier, low 64 bits of a 64x64 product over three steps
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  always_comb begin
    unique case (mstep_q)
      2'd0:    begin mul_a = ma_q[31:0];  mul_b = mb_q[31:0];  end
      2'd1:    begin mul_a = ma_q[31:0];  mul_b = mb_q[63:32]; end
      default: begin mul_a = ma_q[63:32]; mul_b = mb_q[31:0];  end
    endcase
    prod = 64'(mul_a) * 64'(mul_b);
  end

  // next running value
  logic [63:0] n, bx;
  always_comb begin
    bx = {56'd0, b_q};
    case (mode_q)
      MODE_CRC_RIGHT: n = te ^ (c_q >> 8);
      MODE_CRC_LEFT:  n = te ^ (c_q << 8);
      MODE_CRC_APPND: n = ((c_q << 8) | bx) ^ te;
      MODE_ROT_ADD:   n = (c_q >> 1) + ((c_q & 64'd1) << (w - 7'd1)) + bx;
      MODE_XOR:       n = c_q ^ bx;
      MODE_ADD:       n = c_q + bx;
      MODE_CRC_KEEP:  n = te ^ c_q;
      MODE_CRC_HIGH:  n = te ^ (c_q >> (w - 7'd8));
      MODE_SHL_XOR:   n = (c_q << 1) ^ bx;
      MODE_SHL_ADD:   n = (c_q << 1) + bx;
      MODE_DJB2:      n = (c_q << 5) + c_q + bx;
      MODE_MUL_ADD:   n = acc_q + bx;
      MODE_MUL_XOR:   n = acc_q ^ bx;
      MODE_SDBM:      n = bx + (c_q << 6) + (c_q << 16) - c_q;
      default:        n = acc_q;
    endcase
  end

  // final fold for the internet checksum
  logic [63:0] s1, f;
  logic [15:0] fs;
  always_comb begin
    s1 = (run_q >> 16) + (run_q & 64'hffff);
    f  = (s1 + (s1 >> 16)) & 64'hffff;
    fs = {f[7:0], f[15:8]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= '0;
      bidx_q <= '0;
      held_q <= '0;
    end else begin
      if (cmd_i.load) begin
        run_q  <= run_base;
        bidx_q <= idx_base + 1'b1;
      end else if (cmd_i.update) begin
        if (mode_q == MODE_INET) begin
          if (!cidx_q[0]) begin
            held_q <= b_q;
            if (last_q) run_q <= run_q + bx;
          end else begin
            run_q <= run_q + {48'd0, b_q, held_q};
          end
        end else if (is_supported(mode_q)) begin
          run_q <= n & m;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      b_q    <= in_byte_i;
      last_q <= in_last_i;
      c_q    <= run_base & m;
      cidx_q <= idx_base;
    end
    if (cmd_i.tbl_init) begin
      r_q <= seed;
    end else if (cmd_i.tbl_step) begin
      r_q <= rstep;
    end
    if (cmd_i.mul_start) begin
      if (mode_q == MODE_POS_MUL) begin
        ma_q <= 64'(cidx_q) + 64'd1;
        mb_q <= bx;
      end else begin
        ma_q <= (mode_q == MODE_FNV1A) ? (c_q ^ bx) : c_q;
        mb_q <= poly_q;
      end
    end else if (cmd_i.mul_step && mstep_q == 2'd2 && mode_q == MODE_POS_MUL &&
                 !cmd_i.mul_pass2) begin
      ma_q <= c_q + acc_q + {prod[31:0], 32'd0};
      mb_q <= poly_q;
    end
    if (cmd_i.mul_step) begin
      unique case (mstep_q)
        2'd0:    acc_q <= prod;
        default: acc_q <= acc_q + {prod[31:0], 32'd0};
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcnt_q  <= '0;
      mstep_q <= '0;
    end else begin
      if (cmd_i.tbl_init) tcnt_q <= '0;
      else if (cmd_i.tbl_step) tcnt_q <= tcnt_q + 3'd1;
      if (cmd_i.mul_start) mstep_q <= '0;
      else if (cmd_i.mul_step) mstep_q <= (mstep_q == 2'd2) ? 2'd0 : mstep_q + 2'd1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (!is_supported(mode_q)) begin
        out_value_o <= '1;
        out_error_o <= 1'b1;
      end else begin
        out_value_o <= ((mode_q == MODE_INET) ? ({48'd0, fs} ^ fxor_q)
                                              : (run_q ^ fxor_q)) & m;
        out_error_o <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.tbl_mode = is_tbl(mode_q);
    sts_o.mul_mode = is_mul(mode_q);
    sts_o.pos_mode = (mode_q == MODE_POS_MUL);
    sts_o.last     = last_q;
    sts_o.tbl_done = (tcnt_q == 3'd7);
    sts_o.mul_done = (mstep_q == 2'd2);
    sts_o.out_busy = out_valid_o && !out_ready_i;
  end

endmodule

`default_nettype wire

### sv/configurable_crc_hash_engine.sv
// ----------------------------------------------------------------------------
// configurable_crc_hash_engine
// Byte-serial CRC / checksum / hash engine with a register-set algorithm.
// ----------------------------------------------------------------------------
// Usage: message bytes enter on the s_axis channel, tuser marks the first byte
// of a message (running value reloads from initial_value), tlast the final
// one. After each last byte one result leaves on m_axis: tdata holds the
// width-masked value, tuser flags an unsupported mode (value all ones).
// Registers are written over the cfg channel (always ready); the user must
// write them only while idle, the engine does not enforce it. Per byte the
// sequencer steps through load, prepare and update; table CRC modes add
// one polynomial step per cycle over 8 bits, multiply modes three steps
// per product through one shared 32x32 multiplier, two products for the
// position-weighted one. A last byte adds an emit step; the result sits
// in an output register.
// A stalled receiver holds the result; the engine keeps taking bytes and
// waits at the next emit until the register frees up.
// Reset loads default configuration (32-bit reflected CRC) and clears state.
// ----------------------------------------------------------------------------
`default_nettype none

module configurable_crc_hash_engine
  import crch_pkg::*;
#(
  parameter int unsigned INDEX_BITS = IndexBitsDefault
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire  [CfgAddrW-1:0] cfg_addr_i,
  input  wire  [63:0]         cfg_data_i,
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire  [7:0]          s_axis_tdata,   // [7:0] data_byte
  input  wire                 s_axis_tuser,   // [0] first_byte
  input  wire                 s_axis_tlast,   // last_byte
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  output logic [63:0]         m_axis_tdata,   // [63:0] result_value
  output logic                m_axis_tuser    // [0] error
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  crch_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  crch_dp #(.INDEX_BITS(INDEX_BITS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .in_byte_i   (s_axis_tdata),
    .in_first_i  (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (m_axis_tdata),
    .out_error_o (m_axis_tuser)
  );

endmodule

`default_nettype wire
